FILE: rtl/core/min_priority_queue_defines.svh
// assertion macros for the min priority queue
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define MPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/core/mpq_pkg.sv
// types and constants shared by the min priority queue
`timescale 1ns / 1ps
package mpq_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int PORT_COUNT_W = 7;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic               action;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]      top_value;
        logic                    top_valid;
        logic [PORT_COUNT_W-1:0] entry_count;
        logic [1:0]              status;
    } t_out_item;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [VALUE_W-1:0] key;
    } t_cell_ctrl;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      gt;
    } t_cell_link;

endpackage

FILE: rtl/core/mpq_cell.sv
// one sorted storage cell of the queue chain
`timescale 1ns / 1ps
module mpq_cell (
    input  logic                              i_clk,
    input  mpq_pkg::t_cell_ctrl               i_ctrl,
    input  logic                              i_occ,
    input  mpq_pkg::t_cell_link               i_left,
    input  logic signed [mpq_pkg::VALUE_W-1:0] i_right_value,
    output mpq_pkg::t_cell_link               o_link
);
    import mpq_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_gt;

    // empty cells act as plus infinity
    assign w_gt = !i_occ || (r_value > i_ctrl.key);

    always_comb begin
        n_value = r_value;
        unique case (i_ctrl.op)
            OP_INSERT: begin
                if (i_left.gt) begin
                    n_value = i_left.value;
                end else if (w_gt) begin
                    n_value = i_ctrl.key;
                end
            end
            OP_SHIFT: begin
                n_value = i_right_value;
            end
            OP_HOLD: begin
                n_value = r_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.value = r_value;
    assign o_link.gt    = w_gt;

endmodule

FILE: rtl/core/min_priority_queue.sv
// min priority queue: a sorted chain of cells, minimum held in the first cell
// latency: result is presented the cycle after the transaction is accepted
// throughput: one transaction per cycle while the output register is free or being taken
// the output register frees and refills in the same cycle when taken
// reset clears the entry count, status and output valid; cell contents stay undefined
`timescale 1ns / 1ps
`include "min_priority_queue_defines.svh"
module min_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mpq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mpq_pkg::t_out_item o_out_data
);
    import mpq_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    t_status            r_status;
    t_status            n_status;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               w_accept;
    t_cell_ctrl         w_ctrl;

    t_cell_link                w_links  [0:CAPACITY];
    logic signed [VALUE_W-1:0] w_values [0:CAPACITY-1];
    logic                      w_occ    [0:CAPACITY-1];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        w_ctrl.op   = OP_HOLD;
        w_ctrl.key  = VALUE_W'(i_in_data.value);
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            unique case (i_in_data.action)
                ACT_INSERT: begin
                    if (r_count == COUNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.op = OP_INSERT;
                        n_count   = r_count + COUNT_W'(1);
                    end
                end
                ACT_REMOVE: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctrl.op = OP_SHIFT;
                        n_count   = r_count - COUNT_W'(1);
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign w_links[0].value = '0;
    assign w_links[0].gt    = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g]    = r_count > COUNT_W'(g);
        assign w_values[g] = w_links[g+1].value;
        if (g == CAPACITY - 1) begin : g_last
            mpq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_occ         (w_occ[g]),
                .i_left        (w_links[g]),
                .i_right_value (w_values[g]),
                .o_link        (w_links[g+1])
            );
        end else begin : g_mid
            mpq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_occ         (w_occ[g]),
                .i_left        (w_links[g]),
                .i_right_value (w_values[g+1]),
                .o_link        (w_links[g+1])
            );
        end
    end

    // state only moves on a transaction, so the result reads straight from it
    assign o_out_valid            = r_out_valid;
    assign o_out_data.top_valid   = w_occ[0];
    assign o_out_data.top_value   = w_occ[0] ? 32'(w_values[0]) : 32'sd0;
    assign o_out_data.entry_count = PORT_COUNT_W'(r_count);
    assign o_out_data.status      = r_status;

    `MPQ_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_count <= COUNT_W'(CAPACITY), "count over capacity")
    `MPQ_ASSERT(a_insert_grows, i_clk, i_rst_n,
        (w_accept && i_in_data.action == ACT_INSERT && r_count != COUNT_W'(CAPACITY))
        |=> (r_count == $past(r_count) + COUNT_W'(1)), "insert did not grow count")
    `MPQ_ASSERT(a_empty_flag, i_clk, i_rst_n,
        (w_accept && i_in_data.action == ACT_REMOVE && r_count == '0)
        |=> (r_status == ST_EMPTY && r_count == '0), "remove on empty not flagged")
    `MPQ_ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> (!r_out_valid && r_count == '0), "reset left state")

endmodule
